[sv/bbcm_pkg.sv]
// Shared constants and types for the box blur clipped mean unit.
package bbcm_pkg;

  localparam int PIX_W    = 8;
  localparam int HEIGHT_W = 16;
  localparam int WREG_W   = 11;
  localparam int RAD_W    = 2;
  localparam int CFG_W    = 16;
  localparam int IDX_W    = 2;
  localparam int SUM_W    = 14;   // 49 * 255 fits
  localparam int CNT_W    = 6;    // at most 49 window taps

  localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT  = 2'd0;
  localparam logic [IDX_W-1:0] REG_FRAME_WIDTH   = 2'd1;
  localparam logic [IDX_W-1:0] REG_WINDOW_RADIUS = 2'd2;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

endpackage

[sv/box_blur_clipped_mean_unit.sv]
// Box blur with clipped mean: top level joining front, job queue and back.
//
// Usage: 8-bit grayscale pixels enter in raster order on the s_ stream
// (s_tuser[0] low: pixel in s_tdata; high: drain tick). Each result on the
// m_ stream is the truncated mean of the in-frame (2R+1)x(2R+1) window;
// m_tlast marks the last pixel of the frame. Output k is produced once input
// k+R*W+R has arrived; after the last pixel, one drain tick per pending
// output flushes the rest. The user sets registers on cfg_we/cfg_index/
// cfg_data only while the block is idle; the block does not enforce this.
// Each write to a defined register restarts the frame. Throughput: the back
// part reads the window from the line store one tap a cycle, then divides
// one quotient bit a cycle; the front keeps accepting items until the
// two-entry job queue is full.
// After the last output of a frame the front holds s_tready low until the
// back has finished reading the old frame. A stalled receiver holds the
// output register, then the back, then the queue, then s_tready.
// Reset (rst, synchronous): height 480, width 640, radius 1, frame restarted.
module box_blur_clipped_mean_unit #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_RADIUS = 3
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [bbcm_pkg::IDX_W-1:0] cfg_index,
  input  logic [bbcm_pkg::CFG_W-1:0] cfg_data,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [bbcm_pkg::PIX_W-1:0] s_tdata,   // [7:0] pixel_in
  input  logic [0:0]                 s_tuser,   // [0] operation
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [bbcm_pkg::PIX_W-1:0] m_tdata,   // [7:0] pixel_out
  output logic                       m_tlast
);

  localparam int DEPTH = (2*MAX_RADIUS+1)*MAX_WIDTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int WW    = $clog2(MAX_WIDTH+1);
  localparam int LW    = $clog2(3*MAX_WIDTH+5);
  localparam int HW    = bbcm_pkg::HEIGHT_W;
  localparam int JW    = 1 + AW + CW + HW;

  bbcm_pkg::q_status_t        q_status;
  logic                       back_busy;
  logic                       job_push;
  logic                       job_pop;
  logic [HW-1:0]              f_row;
  logic [CW-1:0]              f_col;
  logic [AW-1:0]              f_addr;
  logic                       f_last;
  logic [JW-1:0]              push_data;
  logic [JW-1:0]              pop_data;
  logic                       mem_we;
  logic [AW-1:0]              mem_waddr;
  logic [bbcm_pkg::PIX_W-1:0] mem_wdata;
  logic [WW-1:0]              w_eff;
  logic [HW-1:0]              h_eff;
  logic [bbcm_pkg::RAD_W-1:0] r_eff;
  logic [LW-1:0]              rw_r;

  assign push_data = {f_last, f_addr, f_col, f_row};

  bbcm_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_RADIUS(MAX_RADIUS)) u_front (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .q_status(q_status), .back_busy(back_busy),
    .job_push(job_push), .job_row(f_row), .job_col(f_col), .job_addr(f_addr),
    .job_last(f_last),
    .mem_we(mem_we), .mem_waddr(mem_waddr), .mem_wdata(mem_wdata),
    .w_eff(w_eff), .h_eff(h_eff), .r_eff(r_eff), .rw_r(rw_r)
  );

  bbcm_queue #(.JW(JW)) u_queue (
    .clk(clk), .rst(rst),
    .push(job_push), .push_data(push_data),
    .pop(job_pop), .pop_data(pop_data),
    .status(q_status)
  );

  bbcm_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_RADIUS(MAX_RADIUS)) u_back (
    .clk(clk), .rst(rst),
    .mem_we(mem_we), .mem_waddr(mem_waddr), .mem_wdata(mem_wdata),
    .q_status(q_status), .job_pop(job_pop),
    .job_row(pop_data[HW-1:0]),
    .job_col(pop_data[HW+CW-1:HW]),
    .job_addr(pop_data[HW+CW+AW-1:HW+CW]),
    .job_last(pop_data[JW-1]),
    .w_eff(w_eff), .h_eff(h_eff), .r_eff(r_eff), .rw_r(rw_r),
    .busy(back_busy),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

endmodule

[sv/bbcm_queue.sv]
// Two-entry job queue between the front and back parts.
module bbcm_queue #(
  parameter int JW = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  logic [JW-1:0]       push_data,
  input  logic                pop,
  output logic [JW-1:0]       pop_data,
  output bbcm_pkg::q_status_t status
);

  logic [JW-1:0] entries [2];
  logic          wp;
  logic          rp;
  logic [1:0]    count;
  logic          do_push;
  logic          do_pop;

  assign status.empty = (count == 2'd0);
  assign status.full  = (count == 2'd2);
  assign do_push = push && !status.full;
  assign do_pop  = pop && !status.empty;
  assign pop_data = entries[rp];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wp] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) wp <= ~wp;
      if (do_pop) rp <= ~rp;
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

[sv/bbcm_front.sv]
// Front part: config registers, input position tracking, line store writes, job issue.
module bbcm_front #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_RADIUS = 3
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [bbcm_pkg::IDX_W-1:0]     cfg_index,
  input  logic [bbcm_pkg::CFG_W-1:0]     cfg_data,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [bbcm_pkg::PIX_W-1:0]     s_tdata,
  input  logic [0:0]                     s_tuser,
  input  bbcm_pkg::q_status_t            q_status,
  input  logic                           back_busy,
  output logic                           job_push,
  output logic [bbcm_pkg::HEIGHT_W-1:0]  job_row,
  output logic [$clog2(MAX_WIDTH)-1:0]   job_col,
  output logic [$clog2((2*MAX_RADIUS+1)*MAX_WIDTH)-1:0] job_addr,
  output logic                           job_last,
  output logic                           mem_we,
  output logic [$clog2((2*MAX_RADIUS+1)*MAX_WIDTH)-1:0] mem_waddr,
  output logic [bbcm_pkg::PIX_W-1:0]     mem_wdata,
  output logic [$clog2(MAX_WIDTH+1)-1:0] w_eff,
  output logic [bbcm_pkg::HEIGHT_W-1:0]  h_eff,
  output logic [bbcm_pkg::RAD_W-1:0]     r_eff,
  output logic [$clog2(3*MAX_WIDTH+5)-1:0] rw_r
);

  localparam int DEPTH = (2*MAX_RADIUS+1)*MAX_WIDTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int WW    = $clog2(MAX_WIDTH+1);
  localparam int LW    = $clog2(3*MAX_WIDTH+5);

  logic [bbcm_pkg::HEIGHT_W-1:0] frame_height;
  logic [bbcm_pkg::WREG_W-1:0]   frame_width;
  logic [bbcm_pkg::RAD_W-1:0]    window_radius;

  logic [bbcm_pkg::HEIGHT_W-1:0] in_row;
  logic [CW-1:0]                 in_col;
  logic [AW-1:0]                 in_addr;
  logic                          in_done;
  logic [LW-1:0]                 pending;
  logic [bbcm_pkg::HEIGHT_W-1:0] out_row;
  logic [CW-1:0]                 out_col;
  logic [AW-1:0]                 out_addr;
  logic                          flush_wait;

  logic accept;
  logic drain;
  logic pix_ok;
  logic emit;
  logic in_col_end;
  logic in_row_end;
  logic out_col_end;
  logic out_row_end;

  always_comb begin
    if (frame_width == '0) begin
      w_eff = WW'(1);
    end else if (32'(frame_width) > 32'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(frame_width);
    end
  end

  assign h_eff = (frame_height == '0) ? bbcm_pkg::HEIGHT_W'(1) : frame_height;
  assign r_eff = (32'(window_radius) > 32'(MAX_RADIUS)) ?
                 bbcm_pkg::RAD_W'(MAX_RADIUS) : window_radius;
  assign rw_r  = LW'(32'(r_eff) * 32'(w_eff) + 32'(r_eff));

  assign s_tready = !flush_wait && !q_status.full;
  assign accept   = s_tvalid && s_tready;
  assign drain    = (s_tuser[0] == bbcm_pkg::OP_DRAIN);
  assign pix_ok   = accept && !drain && !in_done;

  assign in_col_end  = (32'(in_col) + 32'd1 == 32'(w_eff));
  assign in_row_end  = (32'(in_row) + 32'd1 == 32'(h_eff));
  assign out_col_end = (32'(out_col) + 32'd1 == 32'(w_eff));
  assign out_row_end = (32'(out_row) + 32'd1 == 32'(h_eff));

  // A pixel emits once the lag from the oldest pending output reaches R*W+R+1.
  always_comb begin
    emit = 1'b0;
    if (pix_ok) begin
      emit = (32'(pending) + 32'd1 == 32'(rw_r) + 32'd1);
    end else if (accept && drain) begin
      emit = in_done && (pending != '0);
    end
  end

  assign job_push  = emit;
  assign job_row   = out_row;
  assign job_col   = out_col;
  assign job_addr  = out_addr;
  assign job_last  = out_col_end && out_row_end;
  assign mem_we    = pix_ok;
  assign mem_waddr = in_addr;
  assign mem_wdata = s_tdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_height  <= bbcm_pkg::HEIGHT_W'(480);
      frame_width   <= bbcm_pkg::WREG_W'(640);
      window_radius <= bbcm_pkg::RAD_W'(1);
      in_row        <= '0;
      in_col        <= '0;
      in_addr       <= '0;
      in_done       <= 1'b0;
      pending       <= '0;
      out_row       <= '0;
      out_col       <= '0;
      out_addr      <= '0;
      flush_wait    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        bbcm_pkg::REG_FRAME_HEIGHT:  frame_height  <= cfg_data;
        bbcm_pkg::REG_FRAME_WIDTH:   frame_width   <= cfg_data[bbcm_pkg::WREG_W-1:0];
        bbcm_pkg::REG_WINDOW_RADIUS: window_radius <= cfg_data[bbcm_pkg::RAD_W-1:0];
        default: ;
      endcase
      if (cfg_index == bbcm_pkg::REG_FRAME_HEIGHT || cfg_index == bbcm_pkg::REG_FRAME_WIDTH ||
          cfg_index == bbcm_pkg::REG_WINDOW_RADIUS) begin
        in_row     <= '0;
        in_col     <= '0;
        in_addr    <= '0;
        in_done    <= 1'b0;
        pending    <= '0;
        out_row    <= '0;
        out_col    <= '0;
        out_addr   <= '0;
        flush_wait <= 1'b0;
      end
    end else if (emit && job_last) begin
      // last output: new frame starts, hold input until the back has read the old one
      in_row     <= '0;
      in_col     <= '0;
      in_addr    <= '0;
      in_done    <= 1'b0;
      pending    <= '0;
      out_row    <= '0;
      out_col    <= '0;
      out_addr   <= '0;
      flush_wait <= 1'b1;
    end else begin
      if (flush_wait && q_status.empty && !back_busy) begin
        flush_wait <= 1'b0;
      end
      if (pix_ok) begin
        in_addr <= (in_addr == AW'(DEPTH-1)) ? '0 : in_addr + AW'(1);
        if (in_col_end) begin
          in_col <= '0;
          in_row <= in_row + bbcm_pkg::HEIGHT_W'(1);
          if (in_row_end) in_done <= 1'b1;
        end else begin
          in_col <= in_col + CW'(1);
        end
        if (!emit) pending <= pending + LW'(1);
      end else if (emit) begin
        pending <= pending - LW'(1);
      end
      if (emit) begin
        out_addr <= (out_addr == AW'(DEPTH-1)) ? '0 : out_addr + AW'(1);
        if (out_col_end) begin
          out_col <= '0;
          out_row <= out_row + bbcm_pkg::HEIGHT_W'(1);
        end else begin
          out_col <= out_col + CW'(1);
        end
      end
    end
  end

endmodule

[sv/bbcm_back.sv]
// Back part: line store, window read sequencer, sum, divider and output register.
module bbcm_back #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_RADIUS = 3
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           mem_we,
  input  logic [$clog2((2*MAX_RADIUS+1)*MAX_WIDTH)-1:0] mem_waddr,
  input  logic [bbcm_pkg::PIX_W-1:0]     mem_wdata,
  input  bbcm_pkg::q_status_t            q_status,
  output logic                           job_pop,
  input  logic [bbcm_pkg::HEIGHT_W-1:0]  job_row,
  input  logic [$clog2(MAX_WIDTH)-1:0]   job_col,
  input  logic [$clog2((2*MAX_RADIUS+1)*MAX_WIDTH)-1:0] job_addr,
  input  logic                           job_last,
  input  logic [$clog2(MAX_WIDTH+1)-1:0] w_eff,
  input  logic [bbcm_pkg::HEIGHT_W-1:0]  h_eff,
  input  logic [bbcm_pkg::RAD_W-1:0]     r_eff,
  input  logic [$clog2(3*MAX_WIDTH+5)-1:0] rw_r,
  output logic                           busy,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [bbcm_pkg::PIX_W-1:0]     m_tdata,
  output logic                           m_tlast
);

  localparam int DEPTH = (2*MAX_RADIUS+1)*MAX_WIDTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RW    = bbcm_pkg::HEIGHT_W + 2;
  localparam int SW    = bbcm_pkg::SUM_W;
  localparam int NW    = bbcm_pkg::CNT_W;

  typedef enum logic [2:0] {S_IDLE, S_READ, S_TAIL, S_DIV, S_OUT} state_t;

  logic [bbcm_pkg::PIX_W-1:0] line_store [DEPTH];
  logic [bbcm_pkg::PIX_W-1:0] rdata;

  state_t                     state;
  logic [AW-1:0]              rd_addr;
  logic signed [RW-1:0]       win_row;
  logic signed [CW+1:0]       win_col;
  logic signed [CW+1:0]       col_start;
  logic [2:0]                 d_cnt;
  logic [2:0]                 e_cnt;
  logic                       prev_valid;
  logic [SW-1:0]              sum;
  logic [NW-1:0]              cnt;
  logic [2:0]                 bit_i;
  logic [bbcm_pkg::PIX_W-1:0] quot;
  logic                       last;

  logic [2:0]                 two_r;
  logic                       cur_valid;
  logic signed [AW:0]         start_diff;
  logic signed [AW+1:0]       row_step;
  logic [AW-1:0]              row_addr;
  logic [SW-1:0]              div_sub;
  logic [SW-1:0]              sum_acc;

  always_ff @(posedge clk) begin
    if (mem_we) line_store[mem_waddr] <= mem_wdata;
  end

  always_ff @(posedge clk) begin
    rdata <= line_store[rd_addr];
  end

  assign two_r = {r_eff, 1'b0};
  assign busy  = (state != S_IDLE);
  assign job_pop = (state == S_IDLE) && !q_status.empty;

  assign cur_valid = (win_row >= 0) && (win_row < $signed({2'b00, h_eff})) &&
                     (win_col >= 0) && (win_col < $signed((CW+2)'(w_eff)));

  assign start_diff = $signed({1'b0, job_addr}) - $signed((AW+1)'(rw_r));

  // next row of the window: step W-2R through the ring, one wrap at most
  always_comb begin
    row_step = $signed({2'b00, rd_addr}) + $signed((AW+2)'(w_eff)) - $signed((AW+2)'(two_r));
    if (row_step < 0) begin
      row_addr = AW'(row_step + $signed((AW+2)'(DEPTH)));
    end else if (row_step >= $signed((AW+2)'(DEPTH))) begin
      row_addr = AW'(row_step - $signed((AW+2)'(DEPTH)));
    end else begin
      row_addr = AW'(row_step);
    end
  end

  assign sum_acc = prev_valid ? sum + SW'(rdata) : sum;
  assign div_sub = SW'(cnt) << bit_i;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      m_tvalid   <= 1'b0;
      prev_valid <= 1'b0;
      rd_addr    <= '0;
    end else begin
      if (m_tvalid && m_tready && state != S_OUT) m_tvalid <= 1'b0;
      case (state)
        S_IDLE: begin
          prev_valid <= 1'b0;
          if (!q_status.empty) begin
            win_row   <= $signed({2'b00, job_row}) - $signed(RW'(r_eff));
            win_col   <= $signed((CW+2)'(job_col)) - $signed((CW+2)'(r_eff));
            col_start <= $signed((CW+2)'(job_col)) - $signed((CW+2)'(r_eff));
            rd_addr   <= (start_diff < 0) ? AW'(start_diff + $signed((AW+1)'(DEPTH))) :
                                            AW'(start_diff);
            d_cnt     <= '0;
            e_cnt     <= '0;
            sum       <= '0;
            cnt       <= '0;
            last      <= job_last;
            state     <= S_READ;
          end
        end
        S_READ: begin
          prev_valid <= cur_valid;
          sum        <= sum_acc;
          if (cur_valid) cnt <= cnt + NW'(1);
          if (d_cnt == two_r) begin
            d_cnt   <= '0;
            win_col <= col_start;
            win_row <= win_row + RW'(1);
            rd_addr <= row_addr;
            if (e_cnt == two_r) begin
              state <= S_TAIL;
            end else begin
              e_cnt <= e_cnt + 3'd1;
            end
          end else begin
            d_cnt   <= d_cnt + 3'd1;
            win_col <= win_col + (CW+2)'(1);
            rd_addr <= (rd_addr == AW'(DEPTH-1)) ? '0 : rd_addr + AW'(1);
          end
        end
        S_TAIL: begin
          prev_valid <= 1'b0;
          sum        <= sum_acc;
          bit_i      <= 3'd7;
          quot       <= '0;
          state      <= S_DIV;
        end
        S_DIV: begin
          // restoring division, one quotient bit a cycle
          if (sum >= div_sub) begin
            sum         <= sum - div_sub;
            quot[bit_i] <= 1'b1;
          end
          if (bit_i == 3'd0) begin
            state <= S_OUT;
          end else begin
            bit_i <= bit_i - 3'd1;
          end
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= (cnt == '0) ? '0 : quot;
            m_tlast  <= last;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[dv/testbench.sv]
// Self-checking stream testbench for the box blur clipped mean unit.
`timescale 1ns / 100ps

module testbench;

  localparam int MAXW = 1024;
  localparam int MAXR = 3;
  localparam int DEPTH = (2 * MAXR + 1) * MAXW;
  localparam int WATCHDOG = 20000;

  typedef struct packed {
    logic       op;
    logic [7:0] pix;
  } blur_item_t;

  typedef struct packed {
    logic [7:0] mean;
    logic       last;
  } blur_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [bbcm_pkg::IDX_W-1:0] cfg_index = '0;
  logic [bbcm_pkg::CFG_W-1:0] cfg_data = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [bbcm_pkg::PIX_W-1:0] s_tdata = '0;
  logic [0:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [bbcm_pkg::PIX_W-1:0] m_tdata;
  logic m_tlast;

  always #1 clk = ~clk;

  box_blur_clipped_mean_unit DUT (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .m_tlast
  );

  // Predictor state
  logic [15:0] reg_height;
  logic [10:0] reg_width;
  logic [1:0]  reg_radius;
  logic [7:0]  pix_ring [DEPTH];
  int unsigned in_row, in_col, out_row, out_col;

  blur_item_t   pending_items[$];
  blur_result_t expected_means[$];
  int errors = 0;
  int results_seen = 0;
  int items_sent = 0;
  int idle_cycles = 0;

  function automatic int unsigned eff_w();
    if (reg_width == 0) return 1;
    if (reg_width > MAXW) return MAXW;
    return reg_width;
  endfunction

  function automatic int unsigned eff_h();
    return (reg_height == 0) ? 1 : reg_height;
  endfunction

  task automatic restart_positions();
    in_row = 0; in_col = 0; out_row = 0; out_col = 0;
  endtask

  function automatic logic [7:0] clipped_mean(int unsigned w, int unsigned h, int unsigned r);
    int unsigned sum, cnt, colsum, c, rr;
    sum = 0; cnt = 0;
    for (int unsigned d = 0; d <= 2 * r; d++) begin
      c = out_col + d;
      colsum = 0;
      if (c < r || c - r >= w) continue;
      c -= r;
      for (int unsigned e = 0; e <= 2 * r; e++) begin
        rr = out_row + e;
        if (rr < r || rr - r >= h) continue;
        rr -= r;
        colsum += pix_ring[(rr * w + c) % DEPTH];
        cnt++;
      end
      sum += colsum & 11'h7FF;
    end
    if (cnt == 0) return 8'd0;
    return 8'((sum / cnt) & 8'hFF);
  endfunction

  task automatic predict_blur(blur_item_t it);
    int unsigned w, h, r, total, recv, nxt;
    blur_result_t res;
    bit emit;
    w = eff_w(); h = eff_h(); r = reg_radius;
    total = h * w;
    emit = 0;
    nxt = out_row * w + out_col;
    if (it.op == bbcm_pkg::OP_PIXEL) begin
      if (in_row >= h) return;
      pix_ring[(in_row * w + in_col) % DEPTH] = it.pix;
      in_col++;
      if (in_col >= w) begin
        in_col = 0;
        in_row++;
      end
      recv = (in_row >= h) ? total : in_row * w + in_col;
      if (nxt < total && recv == nxt + r * w + r + 1) emit = 1;
    end else begin
      if (in_row >= h && nxt < total) emit = 1;
    end
    if (!emit) return;
    res.mean = clipped_mean(w, h, r);
    res.last = 1'b0;
    out_col++;
    if (out_col >= w) begin
      out_col = 0;
      out_row++;
    end
    if (out_row >= h) begin
      res.last = 1'b1;
      restart_positions();
    end
    expected_means.push_back(res);
  endtask

  // Driver: bursts with random gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        predict_blur(blur_item_t'({s_tuser[0], s_tdata}));
        items_sent++;
      end
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          blur_item_t nx;
          nx = pending_items.pop_front();
          s_tvalid <= 1'b1;
          s_tuser <= nx.op;
          s_tdata <= nx.pix;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 30);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall pattern and monitor
  int stall_phase = 0;
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      stall_phase <= stall_phase + 1;
      m_tready <= (stall_phase[8:7] == 2'b00) ? 1'b1 : ($urandom_range(0, 3) != 0);
      if (m_tvalid && m_tready) begin
        blur_result_t want;
        results_seen++;
        if (expected_means.size() == 0) begin
          $display("%0t: unexpected result mean=%0d last=%0b", $time, m_tdata, m_tlast);
          errors++;
        end else begin
          want = expected_means.pop_front();
          if (m_tdata !== want.mean)
            begin
              $display("%0t: mean expected %0d actual %0d", $time, want.mean, m_tdata);
              errors++;
            end
          if (m_tlast !== want.last) begin
            $display("%0t: frame end expected %0b actual %0b", $time, want.last, m_tlast);
            errors++;
          end
        end
      end
    end
  end

  // Watchdog on transfers
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || rst || cfg_we) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("watchdog expired");
      $display("testbench: FAIL");
      $finish;
    end
  end

  task automatic write_reg(logic [bbcm_pkg::IDX_W-1:0] idx, logic [bbcm_pkg::CFG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == bbcm_pkg::REG_FRAME_HEIGHT) reg_height = val[15:0];
    else if (idx == bbcm_pkg::REG_FRAME_WIDTH) reg_width = val[10:0];
    else if (idx == bbcm_pkg::REG_WINDOW_RADIUS) reg_radius = val[1:0];
    if (idx <= bbcm_pkg::REG_WINDOW_RADIUS) restart_positions();
  endtask

  task automatic wait_idle();
    while (pending_items.size() > 0 || s_tvalid || expected_means.size() > 0)
      @(posedge clk);
    // back end may still be reading the old window
    repeat (80) @(posedge clk);
  endtask

  task automatic push_pix(logic [7:0] v);
    pending_items.push_back(blur_item_t'({bbcm_pkg::OP_PIXEL, v}));
  endtask

  task automatic push_drain();
    pending_items.push_back(blur_item_t'({bbcm_pkg::OP_DRAIN, 8'd0}));
  endtask

  // One frame, pixels random (or a fixed value), then drains plus some noise
  task automatic queue_frame(int unsigned w, int unsigned h, int mode);
    int unsigned n;
    n = w * h;
    if ($urandom_range(0, 5) == 0) push_drain(); // early drain: no result
    for (int unsigned i = 0; i < n; i++) begin
      case (mode)
        1: push_pix(8'hFF);
        2: push_pix(8'h00);
        default: push_pix(8'($urandom()));
      endcase
      if ($urandom_range(0, 40) == 0) push_drain();
    end
    if ($urandom_range(0, 3) == 0) push_pix(8'($urandom())); // extra pixel, R>0 drops
    for (int unsigned i = 0; i < n + 2; i++) push_drain();
  endtask

  task automatic run_setting(int unsigned h, int unsigned w, int unsigned r, int frames, int mode);
    write_reg(bbcm_pkg::REG_FRAME_HEIGHT, bbcm_pkg::CFG_W'(h));
    write_reg(bbcm_pkg::REG_FRAME_WIDTH, bbcm_pkg::CFG_W'(w));
    write_reg(bbcm_pkg::REG_WINDOW_RADIUS, bbcm_pkg::CFG_W'(r));
    for (int f = 0; f < frames; f++) begin
      queue_frame(eff_w(), eff_h(), mode);
      wait_idle();
    end
  endtask

  initial begin
    reg_height = 16'd480; reg_width = 11'd640; reg_radius = 2'd1;
    restart_positions();
    for (int i = 0; i < DEPTH; i++) pix_ring[i] = 8'd0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extremes of fields, tiny frames, clamped sizes, all radii
    run_setting(1, 1, 0, 1, 1);
    run_setting(0, 0, 3, 1, 0);          // zero height and width taken as one
    run_setting(2, 3, 3, 1, 1);
    run_setting(3, 2, 1, 1, 2);
    write_reg(2'd3, 16'hFFFF);           // unused index ignored
    run_setting(1, 2047, 0, 0, 0);       // width above maximum clamped, part of a line
    for (int i = 0; i < 120; i++) push_pix(8'($urandom()));
    wait_idle();
    run_setting(65535, 1, 0, 0, 0);      // tallest setting written only
    run_setting(2, 4, 2, 1, 0);

    // Random settings with small frames
    while (items_sent < 760) begin
      run_setting($urandom_range(1, 6), $urandom_range(1, 8), $urandom_range(0, 3),
                  $urandom_range(1, 3), ($urandom_range(0, 7) == 0) ? 1 : 0);
    end
    wait_idle();

    $display("covered %0d items, %0d results, radii 0..3, widths 1..2047",
             items_sent, results_seen);
    if (errors == 0) $display("testbench: PASS");
    else $display("testbench: FAIL");
    $finish;
  end

endmodule
